/* rtl/assert_macros.svh */
// Concurrent assertion helpers, sampled on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/epvt_pkg.sv */
package epvt_pkg;

    localparam int WIN_DEPTH = 5;

    localparam int COUNT_W   = 16;
    localparam int TIME_W    = 32;
    localparam int POS_W     = 32;
    localparam int REVS_W    = 48;
    localparam int VEL_W     = 52;
    localparam int GEAR_W    = 16;
    localparam int FRAC_REVS = 16;
    localparam int VEL_SHIFT = 32;

    localparam logic [GEAR_W-1:0] GEAR_RESET = GEAR_W'(70 * 32);

    localparam int DMAG_W = COUNT_W + $clog2(WIN_DEPTH);
    localparam int DSUM_W = DMAG_W + 1;
    localparam int TSUM_W = TIME_W + $clog2(WIN_DEPTH);
    localparam int DEN_W  = TSUM_W + GEAR_W;
    localparam int NUM_W  = DMAG_W + VEL_SHIFT;
    localparam int SAT_W  = (NUM_W > VEL_W + 1) ? NUM_W : VEL_W + 1;

    localparam int DIV_CNT_W = $clog2(NUM_W + 1);
    localparam int PH_W      = $clog2(((WIN_DEPTH > GEAR_W) ? WIN_DEPTH : GEAR_W) + 1);

    localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

endpackage

/* rtl/epvt_div.sv */
module epvt_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [epvt_pkg::NUM_W-1:0]  num,
    input  logic [epvt_pkg::DEN_W-1:0]  den,
    output logic                        busy,
    output logic [epvt_pkg::NUM_W-1:0]  quo
);
    import epvt_pkg::*;

    logic [NUM_W-1:0]     num_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DIV_CNT_W'(NUM_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy)
        begin
            num_reg <= {num_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign busy = cnt_reg != '0;
    assign quo  = num_reg;

endmodule

/* rtl/encoder_position_velocity_tracker_unit.sv */
// channel  direction  handshake              payload
// req      in         req_valid / req_stall  req_type, counter_value, timestamp_us
// rsp      out        rsp_valid / rsp_stall  count_delta, position_counts,
//                                            position_revs_q16, velocity_q32
// cfg      in         cfg_valid / cfg_ready  gear_ratio
//
// One item at a time: after the req transfer come 5 window sum steps, 16 shift-add
// multiply steps and 51 quotient bits in the two lockstep dividers; the result is then
// handed off, and the next req transfer follows once the unit is back in S_IDLE.
// Reset: gear ratio 2240, counts, time, position and windows zero.
// req_stall is low whenever no item is in work, even while a result waits on rsp_stall.
// A result still held by rsp_stall keeps the next item in S_HOLD until it drains.
module encoder_position_velocity_tracker_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic                                 req_type,
    input  logic signed [epvt_pkg::COUNT_W-1:0]  counter_value,
    input  logic [epvt_pkg::TIME_W-1:0]          timestamp_us,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output logic signed [epvt_pkg::COUNT_W-1:0]  count_delta,
    output logic signed [epvt_pkg::POS_W-1:0]    position_counts,
    output logic signed [epvt_pkg::REVS_W-1:0]   position_revs_q16,
    output logic signed [epvt_pkg::VEL_W-1:0]    velocity_q32,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [epvt_pkg::GEAR_W-1:0]          gear_ratio
);
    import epvt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_HOLD = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [PH_W-1:0]     ph_cnt_reg, ph_cnt_next;
    logic [GEAR_W-1:0]   gear_reg;
    logic [COUNT_W-1:0]  last_count_reg;
    logic [TIME_W-1:0]   last_time_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [COUNT_W-1:0]  dwin_reg [WIN_DEPTH];
    logic [TIME_W-1:0]   twin_reg [WIN_DEPTH];
    logic [DSUM_W-1:0]   dsum_reg;
    logic [TSUM_W-1:0]   tsum_reg;
    logic [DEN_W-1:0]    prod_reg, prod_next;
    logic [GEAR_W-1:0]   gmul_reg;
    logic [COUNT_W-1:0]  delta_reg;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [COUNT_W-1:0]  rsp_delta_reg;
    logic [POS_W-1:0]    rsp_pos_reg;
    logic [REVS_W-1:0]   rsp_revs_reg;
    logic [VEL_W-1:0]    rsp_vel_reg;

    logic                req_fire;
    logic                rsp_load;
    logic                div_start;
    logic [GEAR_W-1:0]   g_eff;
    logic [COUNT_W-1:0]  new_delta;
    logic [TIME_W-1:0]   new_dt;
    logic [POS_W:0]      pos_sum;
    logic                pos_ovf;
    logic [POS_W-1:0]    pos_upd;
    logic                pos_neg;
    logic [POS_W-1:0]    pos_mag;
    logic                dsum_neg;
    logic [DSUM_W-1:0]   dsum_abs;
    logic [NUM_W-1:0]    revs_num;
    logic [NUM_W-1:0]    vel_num;
    logic                div0_busy, div1_busy;
    logic [NUM_W-1:0]    revs_q, vel_q;
    logic [NUM_W-1:0]    revs_signed;
    logic [SAT_W-1:0]    vel_q_ext, vel_q_neg;
    logic [VEL_W-1:0]    vel_val;

    assign req_fire  = req_valid && !req_stall;
    assign req_stall = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;
    assign g_eff     = (gear_reg == '0) ? GEAR_W'(1) : gear_reg;

    assign new_delta = COUNT_W'($unsigned(counter_value) - last_count_reg);
    assign new_dt    = timestamp_us - last_time_reg;
    assign pos_sum   = {pos_reg[POS_W-1], pos_reg}
                     + {{(POS_W+1-COUNT_W){new_delta[COUNT_W-1]}}, new_delta};
    assign pos_ovf   = pos_sum[POS_W] != pos_sum[POS_W-1];
    assign pos_upd   = pos_ovf ? {{(POS_W-COUNT_W){new_delta[COUNT_W-1]}}, new_delta}
                               : pos_sum[POS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gear_reg <= GEAR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            gear_reg <= gear_ratio;
        end
    end

    // control
    always_comb
    begin
        state_next  = state_reg;
        ph_cnt_next = ph_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next  = S_SUM;
                    ph_cnt_next = PH_W'(WIN_DEPTH);
                end
            end
            S_SUM:
            begin
                ph_cnt_next = ph_cnt_reg - PH_W'(1);
                if (ph_cnt_reg == PH_W'(1))
                begin
                    state_next  = S_MUL;
                    ph_cnt_next = PH_W'(GEAR_W);
                end
            end
            S_MUL:
            begin
                ph_cnt_next = ph_cnt_reg - PH_W'(1);
                if (ph_cnt_reg == PH_W'(1))
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!div0_busy && !div1_busy)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign div_start = (state_reg == S_MUL) && (ph_cnt_reg == PH_W'(1));
    assign rsp_load  = (state_reg == S_HOLD) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ph_cnt_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_cnt_reg    <= ph_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
            last_time_reg  <= '0;
            pos_reg        <= '0;
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                dwin_reg[i] <= '0;
                twin_reg[i] <= '0;
            end
        end
        else if (req_fire)
        begin
            if (req_type)
            begin
                pos_reg <= '0;
            end
            else
            begin
                last_count_reg <= $unsigned(counter_value);
                last_time_reg  <= timestamp_us;
                pos_reg        <= pos_upd;
                for (int i = 0; i < WIN_DEPTH - 1; i++)
                begin
                    dwin_reg[i] <= dwin_reg[i+1];
                    twin_reg[i] <= twin_reg[i+1];
                end
                dwin_reg[WIN_DEPTH-1] <= new_delta;
                twin_reg[WIN_DEPTH-1] <= new_dt;
            end
        end
        else if (state_reg == S_SUM)
        begin
            // full rotation over the sum phase leaves the order unchanged
            for (int i = 0; i < WIN_DEPTH - 1; i++)
            begin
                dwin_reg[i] <= dwin_reg[i+1];
                twin_reg[i] <= twin_reg[i+1];
            end
            dwin_reg[WIN_DEPTH-1] <= dwin_reg[0];
            twin_reg[WIN_DEPTH-1] <= twin_reg[0];
        end
    end

    // window sums and time sum times gear ratio, MSB-first shift-add
    assign prod_next = {prod_reg[DEN_W-2:0], 1'b0}
                     + (gmul_reg[GEAR_W-1] ? DEN_W'(tsum_reg) : DEN_W'(0));

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            delta_reg <= req_type ? COUNT_W'(0) : new_delta;
            dsum_reg  <= '0;
            tsum_reg  <= '0;
        end
        else if (state_reg == S_SUM)
        begin
            dsum_reg <= dsum_reg + {{(DSUM_W-COUNT_W){dwin_reg[0][COUNT_W-1]}}, dwin_reg[0]};
            tsum_reg <= tsum_reg + TSUM_W'(twin_reg[0]);
            if (ph_cnt_reg == PH_W'(1))
            begin
                gmul_reg <= g_eff;
                prod_reg <= '0;
            end
        end
        else if (state_reg == S_MUL)
        begin
            gmul_reg <= {gmul_reg[GEAR_W-2:0], 1'b0};
            prod_reg <= prod_next;
        end
    end

    // divider operands
    assign pos_neg  = pos_reg[POS_W-1];
    assign pos_mag  = pos_neg ? (POS_W'(0) - pos_reg) : pos_reg;
    assign revs_num = NUM_W'({pos_mag, {FRAC_REVS{1'b0}}});
    assign dsum_neg = dsum_reg[DSUM_W-1];
    assign dsum_abs = dsum_neg ? (DSUM_W'(0) - dsum_reg) : dsum_reg;
    assign vel_num  = {dsum_abs[DMAG_W-1:0], {VEL_SHIFT{1'b0}}};

    epvt_div u_div_revs (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (revs_num),
        .den   (DEN_W'(g_eff)),
        .busy  (div0_busy),
        .quo   (revs_q)
    );

    epvt_div u_div_vel (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (vel_num),
        .den   (prod_next),
        .busy  (div1_busy),
        .quo   (vel_q)
    );

    // sign and saturation
    assign revs_signed = pos_neg ? (NUM_W'(0) - revs_q) : revs_q;
    assign vel_q_ext   = SAT_W'(vel_q);
    assign vel_q_neg   = SAT_W'(0) - vel_q_ext;

    always_comb
    begin
        if (tsum_reg == '0)
        begin
            vel_val = '0;
        end
        else if (dsum_neg)
        begin
            vel_val = (vel_q_ext > SAT_W'(VEL_MIN)) ? VEL_MIN : vel_q_neg[VEL_W-1:0];
        end
        else
        begin
            vel_val = (vel_q_ext > SAT_W'(VEL_MAX)) ? VEL_MAX : vel_q_ext[VEL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_delta_reg <= delta_reg;
            rsp_pos_reg   <= pos_reg;
            rsp_revs_reg  <= revs_signed[REVS_W-1:0];
            rsp_vel_reg   <= vel_val;
        end
    end

    assign rsp_valid         = rsp_valid_reg;
    assign count_delta       = $signed(rsp_delta_reg);
    assign position_counts   = $signed(rsp_pos_reg);
    assign position_revs_q16 = $signed(rsp_revs_reg);
    assign velocity_q32      = $signed(rsp_vel_reg);

`include "assert_macros.svh"

    `ASSERT_NEXT(a_accept_blocks, req_valid && !req_stall, req_stall, "req transfer not blocking")
    `ASSERT_ALWAYS(a_div_lockstep, div0_busy == div1_busy, "dividers out of step")
    `ASSERT_SAME(a_rsp_from_hold, $rose(rsp_valid), $past(state_reg == S_HOLD), "rsp without hold")
    `ASSERT_NEXT(a_zero_clears, req_valid && !req_stall && req_type, pos_reg == '0, "zero failed")

endmodule

/* dv/epvt_tb_pkg.sv */
package epvt_tb_pkg;

    typedef enum logic {
        REQ_UPDATE = 1'b0,
        REQ_ZERO   = 1'b1
    } req_kind_t;

endpackage

/* dv/epvt_tracker_checker.sv */
module epvt_tracker_checker
    import epvt_pkg::*;
    import epvt_tb_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_stall,
    input  logic                        req_type,
    input  logic signed [COUNT_W-1:0]   counter_value,
    input  logic [TIME_W-1:0]           timestamp_us,
    input  logic                        rsp_valid,
    input  logic                        rsp_stall,
    input  logic signed [COUNT_W-1:0]   count_delta,
    input  logic signed [POS_W-1:0]     position_counts,
    input  logic signed [REVS_W-1:0]    position_revs_q16,
    input  logic signed [VEL_W-1:0]     velocity_q32,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [GEAR_W-1:0]           gear_ratio,
    output int                          outstanding,
    output int                          fail_count
);

    typedef struct {
        logic signed [COUNT_W-1:0] delta;
        logic signed [POS_W-1:0]   pos;
        logic signed [REVS_W-1:0]  revs;
        logic signed [VEL_W-1:0]   vel;
    } tracker_result_t;

    tracker_result_t pending_results[$];
    tracker_result_t want;

    logic [GEAR_W-1:0]         gear_now;
    logic [COUNT_W-1:0]        seen_count;
    logic [TIME_W-1:0]         prev_time;
    logic signed [POS_W-1:0]   pos_total;
    logic signed [COUNT_W-1:0] delta_win [WIN_DEPTH];
    logic [TIME_W-1:0]         time_win [WIN_DEPTH];

    initial fail_count = 0;

    task report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task check_field(input string name, input logic [63:0] got, input logic [63:0] exp_v);
        if (got !== exp_v)
            report_mismatch($sformatf("%s got %0d expected %0d",
                                      name, $signed(got), $signed(exp_v)));
    endtask

    task advance_tracker(input logic kind, input logic [COUNT_W-1:0] cnt,
                         input logic [TIME_W-1:0] ts);
        logic [COUNT_W-1:0]        d;
        logic [TIME_W-1:0]         dt;
        logic signed [COUNT_W-1:0] delta;
        longint                    sum;
        longint                    dsum;
        longint                    geff;
        longint                    revs;
        longint                    vel;
        longint unsigned           tsum;
        tracker_result_t           r;
        delta = '0;
        if (kind == REQ_UPDATE)
        begin
            d = cnt - seen_count;
            delta = signed'(d);
            dt = ts - prev_time;
            seen_count = cnt;
            prev_time = ts;
            for (int k = 1; k < WIN_DEPTH; k++)
            begin
                delta_win[k-1] = delta_win[k];
                time_win[k-1] = time_win[k];
            end
            delta_win[WIN_DEPTH-1] = delta;
            time_win[WIN_DEPTH-1] = dt;
            sum = longint'(pos_total) + longint'(delta);
            if (sum > 64'sd2147483647 || sum < -64'sd2147483648)
                pos_total = delta;
            else
                pos_total = sum[POS_W-1:0];
        end
        else
        begin
            pos_total = '0;
        end
        geff = (gear_now == '0) ? 64'sd1 : longint'(gear_now);
        revs = (longint'(pos_total) * 64'sd65536) / geff;
        dsum = 0;
        tsum = 0;
        for (int k = 0; k < WIN_DEPTH; k++)
        begin
            dsum += longint'(delta_win[k]);
            tsum += time_win[k];
        end
        if (tsum == 0)
        begin
            vel = 0;
        end
        else
        begin
            vel = (dsum * 64'sd4294967296) / longint'(tsum * geff);
            if (vel > 64'sd2251799813685247)
                vel = 64'sd2251799813685247;
            else if (vel < -64'sd2251799813685248)
                vel = -64'sd2251799813685248;
        end
        r.delta = delta;
        r.pos = pos_total;
        r.revs = revs[REVS_W-1:0];
        r.vel = vel[VEL_W-1:0];
        pending_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gear_now = GEAR_RESET;
            seen_count = '0;
            prev_time = '0;
            pos_total = '0;
            for (int k = 0; k < WIN_DEPTH; k++)
            begin
                delta_win[k] = '0;
                time_win[k] = '0;
            end
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                gear_now = gear_ratio;
            if (req_valid && !req_stall)
                advance_tracker(req_type, counter_value, timestamp_us);
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("result with nothing pending, count_delta %0d",
                                              count_delta));
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("count_delta", count_delta, want.delta);
                    check_field("position_counts", position_counts, want.pos);
                    check_field("position_revs_q16", position_revs_q16, want.revs);
                    check_field("velocity_q32", velocity_q32, want.vel);
                end
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

/* dv/encoder_position_velocity_tracker_unit_tb.sv */
module encoder_position_velocity_tracker_unit_tb;

    import epvt_pkg::*;
    import epvt_tb_pkg::*;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_stall;
    logic                       req_type = REQ_UPDATE;
    logic signed [COUNT_W-1:0]  counter_value = '0;
    logic [TIME_W-1:0]          timestamp_us = '0;
    logic                       rsp_valid;
    logic                       rsp_stall = 1'b0;
    logic signed [COUNT_W-1:0]  count_delta;
    logic signed [POS_W-1:0]    position_counts;
    logic signed [REVS_W-1:0]   position_revs_q16;
    logic signed [VEL_W-1:0]    velocity_q32;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [GEAR_W-1:0]          gear_ratio = GEAR_RESET;
    int                         outstanding;
    int                         fail_count;

    bit                         quiet = 1'b0;
    int unsigned                stall_left;
    int unsigned                hold;
    logic [COUNT_W-1:0]         walk_count;
    logic [TIME_W-1:0]          cur_time;
    logic [GEAR_W-1:0]          ratios [7];

    always #6 clk = ~clk;

    encoder_position_velocity_tracker_unit u_dut (.*);

    epvt_tracker_checker u_checker (.*);

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            hold = stall_left;
            if (rsp_valid && !rsp_stall)
                hold = quiet ? 0 : $urandom_range(0, 10);
            if (hold != 0)
            begin
                rsp_stall <= 1'b1;
                stall_left <= hold - 1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                stall_left <= 0;
            end
        end
    end

    task send_item(input req_kind_t kind, input logic [COUNT_W-1:0] cnt,
                   input logic [TIME_W-1:0] ts);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type <= kind;
        counter_value <= cnt;
        timestamp_us <= ts;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task wait_idle;
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task write_gear(input logic [GEAR_W-1:0] value);
        cfg_valid <= 1'b1;
        gear_ratio <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        #12_000_000;
        $display("encoder_position_velocity_tracker_unit_tb: FAIL");
        $finish;
    end

    initial
    begin
        int unsigned sel;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset gear ratio, wraps, half span, empty time window
        send_item(REQ_ZERO,   16'h1234, 32'hDEAD_BEEF);
        send_item(REQ_UPDATE, 16'h0000, 32'h0000_0000);
        send_item(REQ_UPDATE, 16'h0064, 32'h0000_0000);
        send_item(REQ_UPDATE, 16'h7FFF, 32'd1000);
        send_item(REQ_UPDATE, 16'h8000, 32'd2000);
        send_item(REQ_UPDATE, 16'h0000, 32'd3000);
        send_item(REQ_UPDATE, 16'h8000, 32'd3001);
        send_item(REQ_UPDATE, 16'hFFFF, 32'hFFFF_FF00);
        send_item(REQ_UPDATE, 16'h0010, 32'h0000_0100);
        send_item(REQ_UPDATE, 16'hFFF0, 32'hFFFF_FFFF);
        send_item(REQ_ZERO,   16'hFFFF, 32'hFFFF_FFFF);
        send_item(REQ_UPDATE, 16'h5555, 32'hFFFF_FFFF);
        send_item(REQ_UPDATE, 16'hAAAA, 32'hFFFF_FFFF);
        send_item(REQ_UPDATE, 16'h2AAA, 32'hFFFF_FFFF);
        send_item(REQ_UPDATE, 16'h5555, 32'hFFFF_FFFF);
        send_item(REQ_UPDATE, 16'h7FFF, 32'hFFFF_FFFF);
        send_item(REQ_UPDATE, 16'h7FFF, 32'h0000_0000);
        send_item(REQ_ZERO,   16'h0000, 32'h0000_0000);
        walk_count = 16'h7FFF;
        cur_time = 32'h0000_0000;

        ratios = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(1, 65535)), 16'd3,
                   16'($urandom_range(2, 400)), GEAR_RESET};

        for (int p = 0; p < 7; p++)
        begin
            wait_idle();
            write_gear(ratios[p]);
            for (int j = 0; j < 200; j++)
            begin
                if (j % 50 == 0)
                    quiet <= ($urandom_range(0, 3) == 0);
                if (p == 1 && j == 100)
                    wait_idle();
                sel = $urandom_range(0, 99);
                if (sel < 8)
                begin
                    send_item(REQ_ZERO, 16'($urandom), $urandom);
                end
                else
                begin
                    if (sel < 78)
                    begin
                        walk_count = walk_count + 16'($urandom_range(0, 400)) - 16'd200;
                        cur_time = cur_time + $urandom_range(0, 2000);
                    end
                    else if (sel < 88)
                    begin
                        walk_count = walk_count + 16'($urandom);
                        cur_time = cur_time + $urandom_range(0, 200000);
                    end
                    else if (sel < 93)
                    begin
                        walk_count = walk_count + 16'h8000;
                        cur_time = cur_time + $urandom_range(1, 50);
                    end
                    else if (sel < 97)
                    begin
                        walk_count = 16'($urandom);
                        cur_time = $urandom;
                    end
                    else
                    begin
                        walk_count = walk_count + 16'($urandom_range(0, 20)) - 16'd10;
                    end
                    send_item(REQ_UPDATE, walk_count, cur_time);
                end
            end
        end

        wait_idle();
        if (fail_count == 0 && outstanding == 0)
            $display("encoder_position_velocity_tracker_unit_tb: PASS");
        else
            $display("encoder_position_velocity_tracker_unit_tb: FAIL");
        $finish;
    end

endmodule
